// ----- design/bds_pkg.sv -----
// ---------------------------------------------------------------------------
// bds_pkg
// Shared types, constants and helpers for the 2x2 box downsampler.
// ---------------------------------------------------------------------------
`default_nettype none

package bds_pkg;

    localparam int unsigned MAX_WIDTH_DEF  = 4096;
    localparam int unsigned MAX_HEIGHT_DEF = 4096;

    localparam int unsigned PIX_W     = 8;
    localparam int unsigned SUM_W     = 9;
    localparam int unsigned CFG_W     = 13;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] SRC_DIM_RESET = 13'd256;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;

    // word handed from the address stage to the averaging stage
    typedef struct packed {
        logic             emit;      // this pixel closes an output block
        logic             two_px;    // odd right edge: vertical pair only
        logic             row_end;
        logic             frame_end;
        logic [SUM_W-1:0] part_sum;  // bottom-row contribution
    } s1_word_t;

    // zero reads as one, anything above the maximum as the maximum
    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
                                              input int unsigned maxv);
        int unsigned r;
        r = 32'(v);
        if (r == 0) begin
            r = 1;
        end else if (r > maxv) begin
            r = maxv;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/bds_ram.sv -----
// ---------------------------------------------------------------------------
// bds_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module bds_ram #(
    parameter int unsigned WIDTH = 9,
    parameter int unsigned DEPTH = 2048,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- design/bds_ctrl.sv -----
// ---------------------------------------------------------------------------
// bds_ctrl
// Raster counters, dimension registers and line buffer addressing.
// ---------------------------------------------------------------------------
`default_nettype none

module bds_ctrl #(
    parameter int unsigned MAX_WIDTH  = bds_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = bds_pkg::MAX_HEIGHT_DEF,
    localparam int unsigned LINE_DEPTH = (MAX_WIDTH + 1) / 2,
    localparam int unsigned LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          accept,
    input  wire logic [bds_pkg::PIX_W-1:0]     pixel,
    input  wire logic                          cfg_we,
    input  wire logic [bds_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bds_pkg::CFG_W-1:0]     cfg_wdata,
    output logic                               ram_we,
    output logic [LINE_AW-1:0]                 ram_waddr,
    output logic [bds_pkg::SUM_W-1:0]          ram_wdata,
    output logic                               ram_re,
    output logic [LINE_AW-1:0]                 ram_raddr,
    output bds_pkg::s1_word_t                  word
);

    localparam int unsigned CNT_W = $clog2(MAX_WIDTH);
    localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);

    localparam int unsigned RST_W = bds_pkg::clamp_dim(bds_pkg::SRC_DIM_RESET, MAX_WIDTH);
    localparam int unsigned RST_H = bds_pkg::clamp_dim(bds_pkg::SRC_DIM_RESET, MAX_HEIGHT);

    logic [CNT_W-1:0]              col_reg, col_next;
    logic [ROW_W-1:0]              row_reg, row_next;
    logic [bds_pkg::PIX_W-1:0]     pend_reg, pend_next;
    logic [CNT_W-1:0]              wlast_reg, wlast_next;
    logic [ROW_W-1:0]              hlast_reg, hlast_next;
    logic [ROW_W-1:0]              lor_reg, lor_next;   // last output row

    int unsigned                   w_clamped, h_clamped;
    logic                          last_col, odd_col, odd_row;
    logic [bds_pkg::SUM_W-1:0]     pair_sum, px_ext;
    logic [LINE_AW-1:0]            slot;

    always_comb begin
        w_clamped = bds_pkg::clamp_dim(cfg_wdata, MAX_WIDTH);
        h_clamped = bds_pkg::clamp_dim(cfg_wdata, MAX_HEIGHT);

        last_col = (col_reg == wlast_reg);
        odd_col  = col_reg[0];
        odd_row  = row_reg[0];
        px_ext   = bds_pkg::SUM_W'(pixel);
        pair_sum = bds_pkg::SUM_W'(pend_reg) + px_ext;
        slot     = LINE_AW'(col_reg >> 1);

        // even rows store pair sums, odd rows read them back
        ram_we    = accept && !odd_row && (odd_col || last_col);
        ram_waddr = slot;
        ram_wdata = odd_col ? pair_sum : px_ext;
        ram_re    = accept && odd_row && (odd_col || last_col);
        ram_raddr = slot;

        word.emit      = odd_row && (odd_col || last_col);
        word.two_px    = !odd_col;
        word.row_end   = last_col;
        word.frame_end = last_col && (row_reg == lor_reg);
        word.part_sum  = odd_col ? pair_sum : px_ext;
    end

    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        pend_next  = pend_reg;
        wlast_next = wlast_reg;
        hlast_next = hlast_reg;
        lor_next   = lor_reg;

        if (accept) begin
            if (!odd_col) begin
                pend_next = pixel;
            end
            if (last_col) begin
                col_next = '0;
                row_next = (row_reg == hlast_reg) ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end

        if (cfg_we) begin
            case (cfg_index)
                bds_pkg::REG_SRC_WIDTH: begin
                    wlast_next = CNT_W'(w_clamped - 1);
                    col_next   = '0;
                    row_next   = '0;
                end
                bds_pkg::REG_SRC_HEIGHT: begin
                    hlast_next = ROW_W'(h_clamped - 1);
                    lor_next   = ROW_W'((h_clamped & ~32'd1) - 1);
                    col_next   = '0;
                    row_next   = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            pend_reg  <= '0;
            wlast_reg <= CNT_W'(RST_W - 1);
            hlast_reg <= ROW_W'(RST_H - 1);
            lor_reg   <= ROW_W'((RST_H & ~32'd1) - 1);
        end else begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            pend_reg  <= pend_next;
            wlast_reg <= wlast_next;
            hlast_reg <= hlast_next;
            lor_reg   <= lor_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/bds_avg.sv -----
// ---------------------------------------------------------------------------
// bds_avg
// Adds the line buffer sum to the bottom pair, averages, and holds the
// result word in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module bds_avg (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      accept,
    input  wire bds_pkg::s1_word_t         word,
    input  wire logic [bds_pkg::SUM_W-1:0] ram_rdata,
    output logic                           in_ready,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [bds_pkg::PIX_W-1:0]      m_tdata,
    output logic                           m_tlast,
    output logic                           m_tuser
);

    localparam int unsigned TOT_W = bds_pkg::SUM_W + 1;

    logic                         s1_valid_reg, s1_valid_next;
    bds_pkg::s1_word_t            s1_reg;
    logic                         m_valid_reg, m_valid_next;
    logic [bds_pkg::PIX_W-1:0]    m_data_reg;
    logic                         m_last_reg, m_user_reg;
    logic                         s1_go;
    logic [TOT_W-1:0]             total;
    logic [bds_pkg::PIX_W-1:0]    avg;

    always_comb begin
        s1_go    = s1_valid_reg && (!m_valid_reg || m_tready);
        in_ready = !s1_valid_reg || s1_go;

        total = TOT_W'(ram_rdata) + TOT_W'(s1_reg.part_sum);
        avg   = s1_reg.two_px ? bds_pkg::PIX_W'(total >> 1)
                              : bds_pkg::PIX_W'(total >> 2);

        if (accept && word.emit) begin
            s1_valid_next = 1'b1;
        end else if (s1_go) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_go) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && word.emit) begin
            s1_reg <= word;
        end
        if (s1_go) begin
            m_data_reg <= avg;
            m_last_reg <= s1_reg.row_end;
            m_user_reg <= s1_reg.frame_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

// ----- design/box_downsample_2x2_top.sv -----
// ---------------------------------------------------------------------------
// box_downsample_2x2_top
// One mip level of a 2x2 box-filter downsampler for 8-bit grey pixels.
// ---------------------------------------------------------------------------
// Usage:
//  - s_ channel takes source pixels in raster order, one word per pixel.
//  - m_ channel returns ceil(W/2) x floor(H/2) averaged pixels; tlast marks
//    the end of an output row, tuser marks the end of the frame.
//  - cfg port sets source width (index 0) and height (index 1); a write to
//    either restarts the frame. Write only while the block is idle.
//  - Throughput: one pixel per clock while s_tready is high. Even rows write
//    pair sums to the line buffer and odd rows read them back, so the 1R1W
//    line RAM takes at most one write or one read per pixel.
//  - Path: the pixel that closes a block is registered into the RAM read
//    data and the averaging stage, then into the output register once free.
//  - Reset: counters clear, width and height return to 256. The line
//    buffer is not cleared; an odd row only reads what the row above wrote.
//  - A stalled receiver holds the output word; one more result waits in
//    the averaging stage, and s_tready drops only when both are full.
// ---------------------------------------------------------------------------
`default_nettype none

module box_downsample_2x2_top #(
    parameter int unsigned MAX_WIDTH  = bds_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = bds_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,    // [7:0] pixel
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [7:0]                         m_tdata,    // [7:0] avg_pixel
    output logic                               m_tlast,    // row_end
    output logic [0:0]                         m_tuser,    // [0] frame_end
    input  wire logic                          cfg_we,
    input  wire logic [bds_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bds_pkg::CFG_W-1:0]     cfg_wdata
);

    localparam int unsigned LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int unsigned LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    logic                      accept;
    logic                      ram_we, ram_re;
    logic [LINE_AW-1:0]        ram_waddr, ram_raddr;
    logic [bds_pkg::SUM_W-1:0] ram_wdata, ram_rdata;
    bds_pkg::s1_word_t         word;
    logic                      frame_end;

    assign accept = s_tvalid && s_tready;

    bds_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .pixel     (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .word      (word)
    );

    bds_ram #(
        .WIDTH (bds_pkg::SUM_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bds_avg u_avg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .word      (word),
        .ram_rdata (ram_rdata),
        .in_ready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (frame_end)
    );

    assign m_tuser = frame_end;

endmodule

`default_nettype wire

// ----- design/bds_checker.sv -----
// ---------------------------------------------------------------------------
// bds_checker
// Port-level checks for the downsampler, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module bds_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic [0:0] m_tuser
);

    // frame end is always the end of an output row
    a_frame_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("frame end word without row end");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("output word changed while stalled");

endmodule

bind box_downsample_2x2_top bds_checker u_bds_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
